// ===== src/lmcr_pkg.sv =====
package lmcr_pkg;

	localparam int CHAIN_MODULES_DEF = 4;
	localparam int MODULE_ROWS       = 8;
	localparam int ROW_W             = 3;

	// Ten frames per item: eight row frames and two control frames.
	localparam int FRAMES  = 10;
	localparam int FRAME_W = 4;
	localparam logic [FRAME_W-1:0] FRAME_CTL_A = 4'd8;
	localparam logic [FRAME_W-1:0] FRAME_LAST  = 4'd9;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_REFRESH = 2'd1;
	localparam logic [1:0] CMD_INIT    = 2'd2;

	localparam logic REG_RED   = 1'b0;
	localparam logic REG_GREEN = 1'b1;

	localparam logic [15:0] WORD_SHUTDOWN  = 16'h0C00;
	localparam logic [15:0] WORD_WAKE      = 16'h0C01;
	localparam logic [15:0] WORD_SCANLIMIT = 16'h0B07;
	localparam logic [15:0] WORD_INTENSITY = 16'h0A00;
	localparam logic [7:0]  INTENSITY_MAX  = 8'd15;
	localparam logic [7:0]  INTENSITY_RST  = 8'd8;

	typedef struct packed {
		logic                write_en;
		logic                step;
		logic                refresh;
		logic                color;
		logic [FRAME_W-1:0]  frame;
		logic                frame_end;
		logic                last;
	} ctl_cmd_t;

	function automatic logic [3:0] clamp_intensity(input logic [7:0] v);
		logic [3:0] r;
		if (v > INTENSITY_MAX) begin
			r = INTENSITY_MAX[3:0];
		end else begin
			r = v[3:0];
		end
		return r;
	endfunction

endpackage

// ===== src/lmcr_ram.sv =====
module lmcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/lmcr_ctrl.sv =====
module lmcr_ctrl #(
	parameter int CHAIN_MODULES = lmcr_pkg::CHAIN_MODULES_DEF,
	parameter int MW = (CHAIN_MODULES > 1) ? $clog2(CHAIN_MODULES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          cmd,
	input  logic                color,
	input  logic [1:0]          module_req,
	output logic                busy,
	output lmcr_pkg::ctl_cmd_t  ctl,
	output logic [MW-1:0]       mod_idx
);
	import lmcr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;
	localparam logic [MW-1:0] MOD_TOP = MW'(CHAIN_MODULES - 1);

	logic               state_q;
	logic [FRAME_W-1:0] frame_q;
	logic [MW-1:0]      mod_q;
	logic               refresh_q;
	logic               color_q;
	logic               next_color_q;
	logic               accept;
	logic               in_chain;

	assign busy     = (state_q == ST_RUN);
	assign accept   = start && !busy;
	assign in_chain = ({2'b00, module_req} < 4'(CHAIN_MODULES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_q      <= '0;
			mod_q        <= '0;
			refresh_q    <= 1'b0;
			color_q      <= 1'b0;
			next_color_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == CMD_REFRESH || cmd == CMD_INIT)) begin
						state_q   <= ST_RUN;
						frame_q   <= '0;
						mod_q     <= MOD_TOP;
						refresh_q <= (cmd == CMD_REFRESH);
						if (cmd == CMD_REFRESH) begin
							color_q      <= next_color_q;
							next_color_q <= ~next_color_q;
						end else begin
							color_q <= color;
						end
					end
				end
				ST_RUN: begin
					if (mod_q == '0) begin
						mod_q <= MOD_TOP;
						if (frame_q == FRAME_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							frame_q <= frame_q + 1'b1;
						end
					end else begin
						mod_q <= mod_q - 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.write_en  = accept && (cmd == CMD_WRITE) && in_chain;
		ctl.step      = busy;
		ctl.refresh   = refresh_q;
		ctl.color     = color_q;
		ctl.frame     = frame_q;
		ctl.frame_end = (mod_q == '0);
		ctl.last      = (mod_q == '0) && (frame_q == FRAME_LAST);
	end

	assign mod_idx = mod_q;

`ifndef ASSERT_OFF
	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (frame_q <= FRAME_LAST))
		else $error("frame counter out of range");
	a_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_REFRESH) |=> (next_color_q != $past(next_color_q)))
		else $error("refresh did not toggle color");
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && ctl.last) |=> !busy)
		else $error("sequencer ran past last word");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write_en |-> !busy)
		else $error("store write during sequence");
`endif

endmodule

// ===== src/lmcr_datapath.sv =====
module lmcr_datapath #(
	parameter int CHAIN_MODULES = lmcr_pkg::CHAIN_MODULES_DEF,
	parameter int MW = (CHAIN_MODULES > 1) ? $clog2(CHAIN_MODULES) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lmcr_pkg::ctl_cmd_t  ctl,
	input  logic [MW-1:0]       mod_idx,
	input  logic                color,
	input  logic [1:0]          module_req,
	input  logic [2:0]          row,
	input  logic [7:0]          pixels,
	input  logic                wr_en,
	input  logic                wr_index,
	input  logic [7:0]          wr_data,
	output logic                strobe,
	output logic [15:0]         spi_word,
	output logic                select_green,
	output logic                frame_end,
	output logic                last
);
	import lmcr_pkg::*;

	localparam int AW    = 1 + MW + ROW_W;
	localparam int DEPTH = 1 << AW;

	logic [7:0]          red_q;
	logic [7:0]          green_q;
	logic [DEPTH-1:0]    vld_q;
	logic [AW-1:0]       waddr;
	logic [AW-1:0]       raddr;
	logic [7:0]          rdata;
	logic [2:0]          mod3;

	logic                step_s1;
	logic                refresh_s1;
	logic                color_s1;
	logic [FRAME_W-1:0]  frame_s1;
	logic                fend_s1;
	logic                last_s1;
	logic                vld_s1;

	logic [7:0]          pix;
	logic [7:0]          rot;
	logic [7:0]          row_num;
	logic [3:0]          inten;
	logic [15:0]         word_d;
	logic                green_d;

	assign mod3  = {1'b0, module_req};
	assign waddr = {color, mod3[MW-1:0], row};
	assign raddr = {ctl.color, mod_idx, ctl.frame[ROW_W-1:0]};

	lmcr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ctl.write_en),
		.waddr (waddr),
		.wdata (pixels),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= INTENSITY_RST;
			green_q <= INTENSITY_RST;
			vld_q   <= '0;
			step_s1 <= 1'b0;
			strobe  <= 1'b0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_RED) begin
					red_q <= wr_data;
				end else begin
					green_q <= wr_data;
				end
			end
			if (ctl.write_en) begin
				vld_q[waddr] <= 1'b1;
			end
			step_s1 <= ctl.step;
			strobe  <= step_s1;
		end
	end

	always_ff @(posedge clk) begin
		refresh_s1 <= ctl.refresh;
		color_s1   <= ctl.color;
		frame_s1   <= ctl.frame;
		fend_s1    <= ctl.frame_end;
		last_s1    <= ctl.last;
		vld_s1     <= vld_q[raddr];
	end

	always_comb begin
		// never-written entries read as the cleared value
		pix     = vld_s1 ? rdata : 8'h00;
		rot     = {pix[0], pix[7:1]};
		row_num = {4'h0, frame_s1} + 8'd1;
		inten   = clamp_intensity(color_s1 ? green_q : red_q);
		green_d = color_s1;
		if (frame_s1 < FRAME_CTL_A) begin
			word_d = {row_num, refresh_s1 ? rot : 8'h00};
		end else if (frame_s1 == FRAME_CTL_A) begin
			if (refresh_s1) begin
				word_d  = WORD_SHUTDOWN;
				green_d = ~color_s1;
			end else begin
				word_d = WORD_INTENSITY | {12'h000, inten};
			end
		end else begin
			word_d = refresh_s1 ? WORD_WAKE : WORD_SCANLIMIT;
		end
	end

	always_ff @(posedge clk) begin
		spi_word     <= word_d;
		select_green <= green_d;
		frame_end    <= fend_s1;
		last         <= last_s1;
	end

`ifndef ASSERT_OFF
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> frame_end)
		else $error("last word does not close a frame");
`endif

endmodule

// ===== src/led_matrix_chain_refresher_unit.sv =====
// LED matrix chain refresher: pixel store plus word sequencer for a chain
// of 8x8 modules driven in two colour planes.
// Input: an item is taken when start is high and busy is low. cmd selects
// a pixel byte write (color, module_req, row, pixels), a refresh tick, or
// an init of the chain named by color. A write completes at once and never
// raises busy; writes to modules beyond the chain are dropped.
// Output: each chain word appears on spi_word, select_green, frame_end and
// last for one cycle with strobe high; the receiver must take it, there is
// no backpressure. last marks the final word of an item.
// Timing: refresh and init each emit 10 * CHAIN_MODULES words, one per
// cycle, set by the sequencer stepping the pixel store's single read port.
// busy stays high while the sequencer runs; each word passes the store read
// and stage-1 registers, then the output registers, before it shows. The next
// item may start as soon as busy falls, while earlier words still drain.
// Config: wr_en, wr_index and wr_data set the red (0) and green (1)
// intensities; write them only while no sequence is in flight.
// Reset: pixel store reads as zero, next refresh draws red, intensities 8.
module led_matrix_chain_refresher_unit #(
	parameter int CHAIN_MODULES = lmcr_pkg::CHAIN_MODULES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic        color,
	input  logic [1:0]  module_req,
	input  logic [2:0]  row,
	input  logic [7:0]  pixels,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	output logic        strobe,
	output logic [15:0] spi_word,
	output logic        select_green,
	output logic        frame_end,
	output logic        last
);
	import lmcr_pkg::*;

	localparam int MW = (CHAIN_MODULES > 1) ? $clog2(CHAIN_MODULES) : 1;

	ctl_cmd_t      ctl;
	logic [MW-1:0] mod_idx;

	lmcr_ctrl #(.CHAIN_MODULES(CHAIN_MODULES), .MW(MW)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.color      (color),
		.module_req (module_req),
		.busy       (busy),
		.ctl        (ctl),
		.mod_idx    (mod_idx)
	);

	lmcr_datapath #(.CHAIN_MODULES(CHAIN_MODULES), .MW(MW)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.mod_idx      (mod_idx),
		.color        (color),
		.module_req   (module_req),
		.row          (row),
		.pixels       (pixels),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.strobe       (strobe),
		.spi_word     (spi_word),
		.select_green (select_green),
		.frame_end    (frame_end),
		.last         (last)
	);

endmodule
